[sv/cbq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cascaded biquad IIR package
// Shared constants, the control word layout, the microcode ROM and the
// saturation helpers for the cascaded biquad filter core.
// ----------------------------------------------------------------------------
package cbq_pkg;

  // Sizing and configuration
  localparam int MAX_SECTIONS_DEF = 8;
  localparam int COEFS_PER_SEC    = 5;
  localparam int SAMPLE_W         = 32;
  localparam int CODEC_W          = 16;
  localparam int ACT_W            = 4;
  localparam int GAIN_W           = 15;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 15;
  localparam int PC_W             = 4;

  localparam logic [ACT_W-1:0]  RESET_SECTIONS = 4'd8;
  localparam logic [GAIN_W-1:0] RESET_GAIN     = 15'd20000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SECTIONS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN     = 2'd1;

  // Transaction function codes
  localparam logic FUNC_COEF   = 1'b0;
  localparam logic FUNC_FILTER = 1'b1;

  // Coefficient slots within a section
  localparam logic [2:0] SLOT_A1 = 3'd0;
  localparam logic [2:0] SLOT_A2 = 3'd1;
  localparam logic [2:0] SLOT_B0 = 3'd2;
  localparam logic [2:0] SLOT_B1 = 3'd3;
  localparam logic [2:0] SLOT_B2 = 3'd4;

  // Delay word select
  localparam logic DLY_D1 = 1'b0;
  localparam logic DLY_D2 = 1'b1;

  // Multiplier operand select
  localparam logic [2:0] OPB_DLY = 3'd0;
  localparam logic [2:0] OPB_D1  = 3'd1;
  localparam logic [2:0] OPB_D2  = 3'd2;
  localparam logic [2:0] OPB_W   = 3'd3;
  localparam logic [2:0] OPB_X   = 3'd4;

  // Accumulator operations
  localparam logic [2:0] ACC_NOP  = 3'd0;
  localparam logic [2:0] ACC_X    = 3'd1;
  localparam logic [2:0] ACC_SUB  = 3'd2;
  localparam logic [2:0] ACC_LOAD = 3'd3;
  localparam logic [2:0] ACC_ADD  = 3'd4;

  // Sequencer branch types
  localparam logic [1:0] BR_NEXT = 2'd0;
  localparam logic [1:0] BR_LOOP = 2'd1;
  localparam logic [1:0] BR_DONE = 2'd2;

  // Program counter values
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_PRE  = 4'd1;
  localparam logic [PC_W-1:0] PC_T1   = 4'd2;
  localparam logic [PC_W-1:0] PC_T2   = 4'd3;
  localparam logic [PC_W-1:0] PC_T3   = 4'd4;
  localparam logic [PC_W-1:0] PC_T4   = 4'd5;
  localparam logic [PC_W-1:0] PC_T5   = 4'd6;
  localparam logic [PC_W-1:0] PC_T6   = 4'd7;
  localparam logic [PC_W-1:0] PC_T7   = 4'd8;
  localparam logic [PC_W-1:0] PC_G1   = 4'd9;
  localparam logic [PC_W-1:0] PC_G2   = 4'd10;

  // One control word of the sequencer program.
  typedef struct packed {
    logic       rdc;     // read coefficient memory
    logic [2:0] cslot;   // coefficient slot to read
    logic       rdd;     // read delay memory
    logic       dsel;    // delay word for read or write
    logic       mul;     // load product register
    logic [2:0] msel;    // multiplier operand select
    logic       ld1;     // capture d1 from delay read data
    logic       ld2;     // capture d2 from delay read data
    logic       rnd;     // round and saturate the product
    logic [2:0] acc_op;  // accumulator operation
    logic       wsub;    // w = sat(acc - rounded product)
    logic       yadd;    // y = sat(acc + rounded product)
    logic       wrd;     // write delay memory
    logic       inc;     // advance section counter
    logic [1:0] br;      // branch type
    logic       emit;    // load the result register
  } ucode_t;

  // Microcode ROM. Steps T1..T7 form the per-section loop body.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t u;
    u = '0;
    case (pc)
      PC_PRE: begin
        u.rdc = 1'b1; u.cslot = SLOT_A1; u.rdd = 1'b1; u.dsel = DLY_D1;
      end
      PC_T1: begin
        u.rdc = 1'b1; u.cslot = SLOT_A2; u.rdd = 1'b1; u.dsel = DLY_D2;
        u.mul = 1'b1; u.msel = OPB_DLY; u.ld1 = 1'b1; u.acc_op = ACC_X;
      end
      PC_T2: begin
        u.rdc = 1'b1; u.cslot = SLOT_B1;
        u.mul = 1'b1; u.msel = OPB_DLY; u.ld2 = 1'b1; u.rnd = 1'b1;
      end
      PC_T3: begin
        u.rdc = 1'b1; u.cslot = SLOT_B2;
        u.mul = 1'b1; u.msel = OPB_D1; u.rnd = 1'b1; u.acc_op = ACC_SUB;
      end
      PC_T4: begin
        u.rdc = 1'b1; u.cslot = SLOT_B0;
        u.mul = 1'b1; u.msel = OPB_D2; u.rnd = 1'b1; u.wsub = 1'b1;
        u.wrd = 1'b1; u.dsel = DLY_D2;
      end
      PC_T5: begin
        u.mul = 1'b1; u.msel = OPB_W; u.rnd = 1'b1; u.acc_op = ACC_LOAD;
        u.wrd = 1'b1; u.dsel = DLY_D1;
      end
      PC_T6: begin
        u.rnd = 1'b1; u.acc_op = ACC_ADD; u.inc = 1'b1;
      end
      PC_T7: begin
        u.yadd = 1'b1; u.rdc = 1'b1; u.cslot = SLOT_A1;
        u.rdd = 1'b1; u.dsel = DLY_D1; u.br = BR_LOOP;
      end
      PC_G1: begin
        u.mul = 1'b1; u.msel = OPB_X;
      end
      PC_G2: begin
        u.emit = 1'b1; u.br = BR_DONE;
      end
      default: begin
        u = '0;
      end
    endcase
    return u;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate a wide signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sh0000_0000_0000_7FFF) begin
      r = 16'sh7FFF;
    end else if (v < -64'sh0000_0000_0000_8000) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[sv/cbq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cascaded biquad datapath
// Shared multiplier, product rounding, accumulator and the section working
// registers, driven by the sequencer's control word and the sample load.
// ----------------------------------------------------------------------------
module cbq_datapath (
  input  logic                                 clk,
  input  cbq_pkg::ucode_t                      ctrl,
  input  logic                                 load_x,
  input  logic signed [cbq_pkg::SAMPLE_W-1:0]  sample,
  input  logic signed [31:0]                   coef_val,
  input  logic signed [cbq_pkg::SAMPLE_W-1:0]  dly_val,
  input  logic        [cbq_pkg::GAIN_W-1:0]    gain,
  output logic signed [cbq_pkg::SAMPLE_W-1:0]  x_q,
  output logic signed [cbq_pkg::SAMPLE_W-1:0]  d1_q,
  output logic signed [cbq_pkg::SAMPLE_W-1:0]  w_q,
  output logic signed [cbq_pkg::CODEC_W-1:0]   codec
);
  import cbq_pkg::*;

  logic signed [31:0] x_r, d1_r, d2_r, w_r, rnd_r;
  logic signed [33:0] acc_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] opa, opb;
  logic signed [63:0] rnd_full;
  logic signed [33:0] rnd_ext;
  logic signed [63:0] trunc_q;

  // Multiplier operand selection; the gain multiply uses the coefficient side.
  always_comb begin
    opa = (ctrl.msel == OPB_X) ? $signed({{(32-GAIN_W){1'b0}}, gain}) : coef_val;
    case (ctrl.msel)
      OPB_DLY: opb = dly_val;
      OPB_D1:  opb = d1_r;
      OPB_D2:  opb = d2_r;
      OPB_W:   opb = w_r;
      OPB_X:   opb = x_r;
      default: opb = dly_val;
    endcase
  end

  // Round half up to Q8.24: floor((p + 2^27) / 2^28).
  assign rnd_full = (prod_r + 64'sd134217728) >>> 28;
  assign rnd_ext  = 34'(rnd_r);

  // Product, rounding and working registers.
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_r <= opa * opb;
    end
    if (ctrl.rnd) begin
      rnd_r <= sat32(rnd_full);
    end
    if (ctrl.ld1) begin
      d1_r <= dly_val;
    end
    if (ctrl.ld2) begin
      d2_r <= dly_val;
    end
    if (ctrl.wsub) begin
      w_r <= sat32(64'(acc_r - rnd_ext));
    end
    if (load_x) begin
      x_r <= sample;
    end else if (ctrl.yadd) begin
      x_r <= sat32(64'(acc_r + rnd_ext));
    end
    case (ctrl.acc_op)
      ACC_X:    acc_r <= 34'(x_r);
      ACC_SUB:  acc_r <= acc_r - rnd_ext;
      ACC_LOAD: acc_r <= rnd_ext;
      ACC_ADD:  acc_r <= acc_r + rnd_ext;
      default:  acc_r <= acc_r;
    endcase
  end

  // Codec sample: negate the product truncated toward zero, then saturate.
  assign trunc_q = (prod_r + (prod_r[63] ? 64'sd16777215 : 64'sd0)) >>> 24;
  assign codec   = sat16(-trunc_q);

  assign x_q  = x_r;
  assign d1_q = d1_r;
  assign w_q  = w_r;

endmodule

[sv/cascaded_biquad_iir_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cascaded biquad IIR core
// Direct-form-II second-order sections in cascade, run by a microcoded
// sequencer over one shared multiply-round-accumulate datapath.
// ----------------------------------------------------------------------------
// A coefficient-write transaction is accepted and returns nothing.
// A filter transaction runs the per-section loop once per active section on
// the single shared multiplier and the single-port coefficient and delay
// memories, after a setup step and before the output gain steps. Its result
// is loaded at the output step, and the next transaction can be accepted
// once the sequencer has returned to idle. The result sits in an
// output register, so the next transaction can be taken while it waits; the
// sequencer holds at its output step only while the previous result is still
// unaccepted. Coefficient and delay memories read as zero after reset until
// written.
// ----------------------------------------------------------------------------
module cascaded_biquad_iir_core #(
  parameter int MAX_SECTIONS = cbq_pkg::MAX_SECTIONS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_func,
  input  logic        [2:0]                     in_section_sel,
  input  logic        [2:0]                     in_coef_sel,
  input  logic signed [31:0]                    in_coef_value,
  input  logic signed [cbq_pkg::SAMPLE_W-1:0]   in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cbq_pkg::SAMPLE_W-1:0]   out_filtered,
  output logic signed [cbq_pkg::CODEC_W-1:0]    out_codec_sample,
  input  logic                                  cfg_we,
  input  logic        [cbq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [cbq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cbq_pkg::*;

  localparam int CoefDepth = COEFS_PER_SEC * MAX_SECTIONS;
  localparam int DlyDepth  = 2 * MAX_SECTIONS;
  localparam int CW        = $clog2(CoefDepth);
  localparam int DW        = $clog2(DlyDepth);
  localparam int SW        = $clog2(MAX_SECTIONS + 1);

  // Configuration registers
  logic [ACT_W-1:0]  act_r;
  logic [GAIN_W-1:0] gain_r;

  // Sequencer state
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [SW-1:0]   sec_r, n_r, n_clamp;
  ucode_t          ctrl;
  logic            sec_ok, in_acc, filt_acc, out_free, out_load;

  // Memories
  logic signed [31:0] coef_mem_r [CoefDepth];
  logic [CoefDepth-1:0] coef_vld_r;
  logic signed [31:0] coef_rd_r;
  logic               coef_hit_r;
  logic signed [31:0] dly_mem_r [DlyDepth];
  logic [DlyDepth-1:0]  dly_vld_r;
  logic signed [31:0] dly_rd_r;
  logic               dly_hit_r;
  logic               coef_we, coef_re, dly_we, dly_re;
  logic [CW-1:0]      coef_waddr, coef_raddr;
  logic [DW-1:0]      dly_addr;
  logic signed [31:0] coef_val, dly_val, dly_wdata;

  // Datapath outputs
  logic signed [SAMPLE_W-1:0] x_q, d1_q, w_q;
  logic signed [CODEC_W-1:0]  codec;

  // Output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_filtered_r;
  logic signed [CODEC_W-1:0]  out_codec_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= RESET_SECTIONS;
      gain_r <= RESET_GAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_SECTIONS: act_r  <= cfg_wdata[ACT_W-1:0];
        CFG_OUTPUT_GAIN:     gain_r <= cfg_wdata[GAIN_W-1:0];
        default:             act_r  <= act_r;
      endcase
    end
  end

  // Section count, clamped to the supported range.
  always_comb begin
    if (act_r == '0) begin
      n_clamp = SW'(1);
    end else if (int'(act_r) > MAX_SECTIONS) begin
      n_clamp = SW'(MAX_SECTIONS);
    end else begin
      n_clamp = SW'(act_r);
    end
  end

  // Input handshake and decode.
  assign in_ready = (pc_r == PC_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign filt_acc = in_acc && (in_func == FUNC_FILTER);
  assign coef_we  = in_acc && (in_func == FUNC_COEF)
                    && (int'(in_coef_sel) < COEFS_PER_SEC)
                    && (int'(in_section_sel) < MAX_SECTIONS);

  // Control word and sequencing.
  assign ctrl     = ucode_rom(pc_r);
  assign sec_ok   = sec_r < n_r;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = ctrl.emit && out_free;

  always_comb begin
    pc_nxt = pc_r;
    if (pc_r == PC_IDLE) begin
      if (filt_acc) begin
        pc_nxt = PC_PRE;
      end
    end else begin
      case (ctrl.br)
        BR_LOOP: pc_nxt = sec_ok ? PC_T1 : pc_r + PC_W'(1);
        BR_DONE: pc_nxt = out_free ? PC_IDLE : pc_r;
        default: pc_nxt = pc_r + PC_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= PC_IDLE;
      sec_r <= '0;
      n_r   <= SW'(1);
    end else begin
      pc_r <= pc_nxt;
      if (filt_acc) begin
        sec_r <= '0;
        n_r   <= n_clamp;
      end else if (ctrl.inc) begin
        sec_r <= sec_r + SW'(1);
      end
    end
  end

  // Coefficient memory: written by transactions, read by the sequencer.
  assign coef_waddr = CW'(int'(in_section_sel) * COEFS_PER_SEC + int'(in_coef_sel));
  assign coef_raddr = CW'(int'(sec_r) * COEFS_PER_SEC + int'(ctrl.cslot));
  assign coef_re    = ctrl.rdc && sec_ok;

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem_r[coef_waddr] <= in_coef_value;
    end
    if (coef_re) begin
      coef_rd_r  <= coef_mem_r[coef_raddr];
      coef_hit_r <= coef_vld_r[coef_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else if (coef_we) begin
      coef_vld_r[coef_waddr] <= 1'b1;
    end
  end

  assign coef_val = coef_hit_r ? coef_rd_r : '0;

  // Delay memory: d1 at even and d2 at odd entries of each section.
  assign dly_addr  = DW'(int'(sec_r) * 2 + int'(ctrl.dsel));
  assign dly_re    = ctrl.rdd && sec_ok;
  assign dly_we    = ctrl.wrd;
  assign dly_wdata = (ctrl.dsel == DLY_D2) ? d1_q : w_q;

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem_r[dly_addr] <= dly_wdata;
    end
    if (dly_re) begin
      dly_rd_r  <= dly_mem_r[dly_addr];
      dly_hit_r <= dly_vld_r[dly_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r <= '0;
    end else if (dly_we) begin
      dly_vld_r[dly_addr] <= 1'b1;
    end
  end

  assign dly_val = dly_hit_r ? dly_rd_r : '0;

  // Shared arithmetic datapath.
  cbq_datapath u_datapath (
    .clk      (clk),
    .ctrl     (ctrl),
    .load_x   (filt_acc),
    .sample   (in_sample_in),
    .coef_val (coef_val),
    .dly_val  (dly_val),
    .gain     (gain_r),
    .x_q      (x_q),
    .d1_q     (d1_q),
    .w_q      (w_q),
    .codec    (codec)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_filtered_r <= x_q;
      out_codec_r    <= codec;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_filtered     = out_filtered_r;
  assign out_codec_sample = out_codec_r;

  // The section counter never runs past the section count of the transaction.
  a_sec_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r != PC_IDLE) |-> (sec_r <= n_r))
    else $error("section counter beyond active section count");

  // A filter transaction always starts the program at its first step.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    filt_acc |=> (pc_r == PC_PRE))
    else $error("filter transaction did not start the program");

  // A result only appears from the output step of the program.
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(pc_r) == PC_G2))
    else $error("result loaded outside the output step");

  // The delay memory port is never asked to read and write at once.
  a_dly_port: assert property (@(posedge clk) disable iff (!rst_n)
    dly_we |-> !dly_re && (pc_r == PC_T4 || pc_r == PC_T5))
    else $error("delay memory port conflict");

endmodule

[tb/sv/tb_cascaded_biquad_iir_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cascaded biquad IIR core testbench
// Sends coefficient-write and filter transactions with random gaps on both
// handshakes. Every filter result is compared field by field with a typed row's
// known value or a shadow filter that keeps its own coefficient table, delay words
// and settings. It walks several section counts and gains, extremes included.
// ----------------------------------------------------------------------------
module tb_cascaded_biquad_iir_core;
  import cbq_pkg::*;

  // Run sizing
  localparam int IDLE_CYCLES  = 7 * MAX_SECTIONS_DEF + 4 + 20;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int MAX_REPORTS  = 30;
  localparam int MAX_GAP      = 13;
  localparam int NUM_PHASES   = 6;

  // Fixed-point helpers for the shadow filter
  localparam longint ROUND_HALF = 64'sd134217728;   // half of one Q4.28 unit
  localparam longint CODEC_ONE  = 64'sd16777216;    // one in Q8.24

  // Stimulus value ranges
  localparam logic [31:0] COEF_SPAN   = 32'h0C00_0000;  // 0.75 in Q4.28
  localparam logic [31:0] SAMPLE_SPAN = 32'h0400_0000;  // 4.0 in Q8.24
  localparam logic [31:0] COEF_ONE    = 32'h1000_0000;
  localparam logic [31:0] COEF_M_ONE  = 32'hF000_0000;
  localparam logic [31:0] WORD_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_MIN    = 32'h8000_0000;

  // Coefficient slots the core must ignore, and unused register indexes
  localparam logic [2:0]           SLOT_BAD_LO = 3'd5;
  localparam logic [2:0]           SLOT_BAD_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3  = 2'd3;

  typedef struct packed {
    logic        func;
    logic [2:0]  section_sel;
    logic [2:0]  coef_sel;
    logic [31:0] coef_value;
    logic [31:0] sample_in;
  } iir_req_t;

  typedef struct packed {
    logic [31:0] filtered;
    logic [15:0] codec;
  } iir_out_t;

  typedef struct packed {
    iir_req_t req;
    logic     typed;
    iir_out_t known;
  } dir_row_t;

  // Clock, reset and block ports
  logic                         clk              = 1'b0;
  logic                         rst_n            = 1'b0;
  logic                         in_valid         = 1'b0;
  logic                         in_ready;
  logic                         in_func          = 1'b0;
  logic        [2:0]            in_section_sel   = '0;
  logic        [2:0]            in_coef_sel      = '0;
  logic signed [31:0]           in_coef_value    = '0;
  logic signed [SAMPLE_W-1:0]   in_sample_in     = '0;
  logic                         out_valid;
  logic                         out_ready        = 1'b0;
  logic signed [SAMPLE_W-1:0]   out_filtered;
  logic signed [CODEC_W-1:0]    out_codec_sample;
  logic                         cfg_we           = 1'b0;
  logic        [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic        [CFG_DATA_W-1:0] cfg_wdata        = '0;

  // Shadow filter state and settings
  logic signed [31:0] coef_shadow  [COEFS_PER_SEC*MAX_SECTIONS_DEF];
  logic signed [31:0] delay_shadow [2*MAX_SECTIONS_DEF];
  logic [ACT_W-1:0]   sections_cfg;
  logic [GAIN_W-1:0]  gain_cfg;

  // Results still owed by the core, oldest first
  iir_out_t pending_outputs[$];
  dir_row_t dir_rows[$];

  // Bookkeeping
  int errors       = 0;
  int items_sent   = 0;
  int coef_writes  = 0;
  int results_seen = 0;
  int src_gap      = 0;
  bit src_calm     = 1'b0;
  bit sink_calm    = 1'b0;

  // Register settings of the random phases
  int phase_sections[NUM_PHASES] = '{1, 0, 15, 4, 8, 2};
  int phase_gain[NUM_PHASES]     = '{32767, 0, 1, 12345, 20000, 7000};
  int phase_items[NUM_PHASES]    = '{150, 100, 150, 200, 250, 200};

  cascaded_biquad_iir_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_section_sel   (in_section_sel),
    .in_coef_sel      (in_coef_sel),
    .in_coef_value    (in_coef_value),
    .in_sample_in     (in_sample_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_filtered     (out_filtered),
    .out_codec_sample (out_codec_sample),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb_cascaded_biquad_iir_core: FAIL");
    $finish;
  end

  // Clamp a wide value to the signed 32-bit range.
  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return WORD_MIN;
    end
    return v[31:0];
  endfunction

  // Q4.28 coefficient times Q8.24 value, rounded half up to Q8.24 and clamped.
  function automatic logic signed [31:0] q_mul(input logic signed [31:0] c,
                                               input logic signed [31:0] v);
    longint p;
    p = longint'(c) * longint'(v) + ROUND_HALF;
    return clip32(p >>> 28);
  endfunction

  // Run one sample through the active sections and form the codec sample.
  function automatic iir_out_t cascade_filter(input logic signed [31:0] sample);
    iir_out_t o;
    int n, s, base;
    logic signed [31:0] x, y, d1, d2, w;
    longint scaled;
    n = (sections_cfg == 0) ? 1 : int'(sections_cfg);
    if (n > MAX_SECTIONS_DEF) n = MAX_SECTIONS_DEF;
    x = sample;
    y = '0;
    for (s = 0; s < n; s++) begin
      base = COEFS_PER_SEC * s;
      d1 = delay_shadow[2*s];
      d2 = delay_shadow[2*s+1];
      w = clip32(longint'(x) - longint'(q_mul(coef_shadow[base+SLOT_A1], d1))
                 - longint'(q_mul(coef_shadow[base+SLOT_A2], d2)));
      y = clip32(longint'(q_mul(coef_shadow[base+SLOT_B0], w))
                 + longint'(q_mul(coef_shadow[base+SLOT_B1], d1))
                 + longint'(q_mul(coef_shadow[base+SLOT_B2], d2)));
      delay_shadow[2*s+1] = d1;
      delay_shadow[2*s]   = w;
      x = y;
    end
    // The divide truncates toward zero before the 16-bit clamp.
    scaled = (-longint'(y) * longint'(gain_cfg)) / CODEC_ONE;
    if (scaled > 64'sd32767) begin
      scaled = 64'sd32767;
    end else if (scaled < -64'sd32768) begin
      scaled = -64'sd32768;
    end
    o.filtered = y;
    o.codec    = scaled[15:0];
    return o;
  endfunction

  // Random transaction: mostly moderate values, some raw words and extremes.
  function automatic iir_req_t random_req();
    iir_req_t r;
    int pick;
    r.func        = ($urandom_range(0, 99) < 68) ? FUNC_FILTER : FUNC_COEF;
    r.section_sel = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) begin
      r.coef_sel = 3'($urandom_range(SLOT_BAD_LO, SLOT_BAD_HI));
    end else begin
      r.coef_sel = 3'($urandom_range(SLOT_A1, SLOT_B2));
    end
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      r.coef_value = $urandom_range(0, 2 * COEF_SPAN) - COEF_SPAN;
    end else if (pick < 85) begin
      r.coef_value = $urandom;
    end else begin
      case ($urandom_range(0, 2))
        0:       r.coef_value = COEF_ONE;
        1:       r.coef_value = COEF_M_ONE;
        default: r.coef_value = '0;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      r.sample_in = $urandom_range(0, 2 * SAMPLE_SPAN) - SAMPLE_SPAN;
    end else if (pick < 85) begin
      r.sample_in = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0:       r.sample_in = WORD_MAX;
        1:       r.sample_in = WORD_MIN;
        2:       r.sample_in = '0;
        default: r.sample_in = '1;
      endcase
    end
    return r;
  endfunction

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic add_row(input logic func, input logic [2:0] sec, input logic [2:0] slot,
                         input logic [31:0] coef, input logic [31:0] sample,
                         input logic typed, input logic [31:0] filt, input logic [15:0] codec);
    dir_row_t row;
    row.req   = '{func, sec, slot, coef, sample};
    row.typed = typed;
    row.known = '{filt, codec};
    dir_rows.push_back(row);
  endtask

  // Update the shadow state for an accepted transaction and queue its result.
  task automatic record_accept(input iir_req_t r, input logic typed, input iir_out_t known);
    iir_out_t p;
    items_sent++;
    if (r.func == FUNC_COEF) begin
      coef_writes++;
      if (r.coef_sel <= SLOT_B2) begin
        coef_shadow[COEFS_PER_SEC * r.section_sel + r.coef_sel] = r.coef_value;
      end
    end else begin
      p = cascade_filter(r.sample_in);
      pending_outputs.push_back(typed ? known : p);
    end
  endtask

  // Offer one transaction and hold it until the core takes it.
  task automatic send_item(input iir_req_t r, input logic typed, input iir_out_t known);
    repeat (src_gap) @(posedge clk);
    in_valid       <= 1'b1;
    in_func        <= r.func;
    in_section_sel <= r.section_sel;
    in_coef_sel    <= r.coef_sel;
    in_coef_value  <= r.coef_value;
    in_sample_in   <= r.sample_in;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    record_accept(r, typed, known);
    // Valid stays up only when the next transaction follows at once.
    src_gap = draw_gap(src_calm);
    if (src_gap != 0) in_valid <= 1'b0;
  endtask

  task automatic stop_sending();
    if (src_gap == 0) begin
      in_valid <= 1'b0;
      src_gap = 1;
    end
  endtask

  // Wait until every owed result has come, then let the core go quiet.
  task automatic settle(input int extra);
    int guard;
    stop_sending();
    guard = 0;
    while (pending_outputs.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_ACTIVE_SECTIONS: sections_cfg = data[ACT_W-1:0];
      CFG_OUTPUT_GAIN:     gain_cfg = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Compare one accepted result with the oldest expectation.
  task automatic check_result();
    iir_out_t want;
    results_seen++;
    if (pending_outputs.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: unexpected result: expected none, actual filtered %0d codec %0d",
                 $time, out_filtered, out_codec_sample);
      end
    end else begin
      want = pending_outputs.pop_front();
      if (out_filtered !== want.filtered) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: filtered mismatch: expected %0d, actual %0d",
                   $time, $signed(want.filtered), out_filtered);
        end
      end
      if (out_codec_sample !== want.codec) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: codec_sample mismatch: expected %0d, actual %0d",
                   $time, $signed(want.codec), out_codec_sample);
        end
      end
    end
  endtask

  // Result side: random stalls before each result, with calm stretches.
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_gap(sink_calm);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      check_result();
      if (results_seen % 40 == 0) sink_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Stimulus: directed table first, then random phases under several settings.
  initial begin : stimulus
    iir_req_t         r;
    iir_out_t         none;
    logic [CFG_DATA_W-1:0] data;
    int ph, k, i;
    none = '0;
    for (i = 0; i < COEFS_PER_SEC * MAX_SECTIONS_DEF; i++) coef_shadow[i] = '0;
    for (i = 0; i < 2 * MAX_SECTIONS_DEF; i++) delay_shadow[i] = '0;
    sections_cfg = RESET_SECTIONS;
    gain_cfg     = RESET_GAIN;

    // Table: all-zero coefficients give silence; bad slots are dropped; a
    // unity chain ending in -8.0 gives a codec value past the clamp.
    add_row(FUNC_FILTER, 3'd7, 3'd7, 32'hFFFF_FFFF, WORD_MAX, 1'b1, '0, '0);
    add_row(FUNC_FILTER, 3'd0, 3'd0, '0, WORD_MIN, 1'b1, '0, '0);
    add_row(FUNC_COEF, 3'd7, SLOT_B2, WORD_MAX, 32'h1234_5678, 1'b0, '0, '0);
    add_row(FUNC_COEF, 3'd0, SLOT_BAD_LO, WORD_MAX, '0, 1'b0, '0, '0);
    add_row(FUNC_COEF, 3'd3, SLOT_BAD_HI, WORD_MIN, '1, 1'b0, '0, '0);
    for (i = 0; i < 7; i++) begin
      add_row(FUNC_COEF, i[2:0], SLOT_B0, COEF_ONE, $urandom, 1'b0, '0, '0);
    end
    add_row(FUNC_COEF, 3'd7, SLOT_B0, WORD_MIN, '0, 1'b0, '0, '0);
    add_row(FUNC_FILTER, 3'd5, 3'd2, '1, 32'h0100_0000, 1'b1, 32'hF800_0000, 16'h7FFF);
    add_row(FUNC_COEF, 3'd0, SLOT_A1, WORD_MIN, '1, 1'b0, '0, '0);
    add_row(FUNC_COEF, 3'd3, SLOT_A2, WORD_MAX, '0, 1'b0, '0, '0);
    add_row(FUNC_COEF, 3'd0, SLOT_B1, COEF_ONE, '0, 1'b0, '0, '0);
    add_row(FUNC_COEF, 3'd1, SLOT_B2, COEF_M_ONE, '0, 1'b0, '0, '0);
    add_row(FUNC_FILTER, 3'd0, 3'd0, '0, WORD_MAX, 1'b0, '0, '0);
    add_row(FUNC_FILTER, 3'd7, 3'd7, '1, WORD_MIN, 1'b0, '0, '0);
    add_row(FUNC_FILTER, 3'd0, 3'd0, '0, '0, 1'b0, '0, '0);
    add_row(FUNC_FILTER, 3'd2, 3'd4, 32'h5555_5555, '1, 1'b0, '0, '0);
    add_row(FUNC_COEF, 3'd0, SLOT_A1, '0, '0, 1'b0, '0, '0);
    add_row(FUNC_FILTER, 3'd0, 3'd0, '0, 32'h0080_0000, 1'b0, '0, '0);
    add_row(FUNC_FILTER, 3'd0, 3'd0, '0, 32'hFF00_0000, 1'b0, '0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[j]) send_item(dir_rows[j].req, dir_rows[j].typed, dir_rows[j].known);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // Registers change only while the core is idle.
      settle(IDLE_CYCLES);
      data = CFG_DATA_W'($urandom);
      data[ACT_W-1:0] = ACT_W'(phase_sections[ph]);
      write_reg(CFG_ACTIVE_SECTIONS, data);
      write_reg(CFG_OUTPUT_GAIN, CFG_DATA_W'(phase_gain[ph]));
      if (ph == 3) begin
        // Unused indexes must leave both registers alone.
        write_reg(CFG_SPARE2, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE3, CFG_DATA_W'($urandom));
      end
      cfg_we <= 1'b0;
      for (k = 0; k < phase_items[ph]; k++) begin
        if (k % 40 == 0) src_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 59) == 0) settle(0);
        r = random_req();
        send_item(r, 1'b0, none);
      end
    end

    settle(IDLE_CYCLES);
    if (pending_outputs.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_outputs.size());
    end
    $display("Covered %0d transactions, %0d of them coefficient writes, and %0d checked results,",
             items_sent, coef_writes, results_seen);
    $display("across section counts 0 to 15, gains 0 to 32767 and unused register indexes.");
    if (errors == 0) begin
      $display("tb_cascaded_biquad_iir_core: PASS");
    end else begin
      $display("tb_cascaded_biquad_iir_core: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/cbq_pkg.sv
sv/cbq_datapath.sv
sv/cascaded_biquad_iir_core.sv
tb/sv/tb_cascaded_biquad_iir_core.sv
